### src/kce_pkg.sv
// Package for the keypad calculator engine.
// Holds key codes, operator, phase and display kind codes, and the arithmetic unit
// handshake structs. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

	typedef logic [1:0] kce_op_t;
	typedef logic [1:0] kce_phase_t;
	typedef logic [2:0] kce_kind_t;
	typedef logic [7:0] kce_char_t;

	localparam kce_op_t OP_ADD = 2'd0;
	localparam kce_op_t OP_SUB = 2'd1;
	localparam kce_op_t OP_MUL = 2'd2;
	localparam kce_op_t OP_DIV = 2'd3;

	localparam kce_phase_t PH_DIGIT = 2'd0;
	localparam kce_phase_t PH_SIGN  = 2'd1;
	localparam kce_phase_t PH_EQUAL = 2'd2;

	localparam kce_kind_t KIND_ENTRY = 3'd0;
	localparam kce_kind_t KIND_OPRES = 3'd1;
	localparam kce_kind_t KIND_EQRES = 3'd2;
	localparam kce_kind_t KIND_ZDIV  = 3'd3;
	localparam kce_kind_t KIND_CLEAR = 3'd4;

	localparam kce_char_t KEY_PLUS  = 8'h2B;
	localparam kce_char_t KEY_MINUS = 8'h2D;
	localparam kce_char_t KEY_STAR  = 8'h2A;
	localparam kce_char_t KEY_SLASH = 8'h2F;
	localparam kce_char_t KEY_EQUAL = 8'h3D;
	localparam kce_char_t KEY_CLEAR = 8'h43;
	localparam kce_char_t KEY_ZERO  = 8'h30;
	localparam kce_char_t KEY_NINE  = 8'h39;
	localparam kce_char_t CHAR_NONE = 8'h00;

	typedef struct packed {
		logic    start;
		kce_op_t op;
	} kce_alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kce_alu_stat_t;

endpackage

`default_nettype wire

### src/kce_alu.sv
// Shared iterative arithmetic unit: registered add/subtract, shift-add multiply
// and restoring divide, one bit per cycle. Depends on kce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kce_alu #(
	parameter int WORD_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire kce_pkg::kce_alu_req_t   req,
	input  wire  [WORD_WIDTH-1:0]        opa,
	input  wire  [WORD_WIDTH-1:0]        opb,
	output kce_pkg::kce_alu_stat_t       stat,
	output logic [WORD_WIDTH-1:0]        result
);
	import kce_pkg::*;

	localparam int CW = $clog2(WORD_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	kce_op_t               op_q;
	logic [CW-1:0]         cnt_q;
	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [WORD_WIDTH:0]   acc_q;
	logic [WORD_WIDTH:0]   rem_sh;
	logic [WORD_WIDTH:0]   rem_sub;
	logic                  rem_ge;

	assign rem_sh  = {acc_q[WORD_WIDTH-1:0], a_q[WORD_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, b_q};
	assign rem_ge  = rem_sh >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_ADD;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				cnt_q <= '0;
				a_q   <= opa;
				b_q   <= opb;
				unique case (req.op)
					OP_ADD: begin
						acc_q  <= {1'b0, opa + opb};
						done_q <= 1'b1;
					end
					OP_SUB: begin
						acc_q  <= {1'b0, opa - opb};
						done_q <= 1'b1;
					end
					default: begin
						acc_q  <= '0;
						busy_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					if (b_q[0]) begin
						acc_q <= {1'b0, acc_q[WORD_WIDTH-1:0] + a_q};
					end
					a_q <= {a_q[WORD_WIDTH-2:0], 1'b0};
					b_q <= {1'b0, b_q[WORD_WIDTH-1:1]};
				end else begin
					acc_q <= rem_ge ? rem_sub : rem_sh;
					a_q   <= {a_q[WORD_WIDTH-2:0], rem_ge};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WORD_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = (op_q == OP_DIV) ? a_q : acc_q[WORD_WIDTH-1:0];

endmodule

`default_nettype wire

### src/keypad_calculator_engine.sv
// Keypad calculator engine: key decode, sequencer and result register.
// Depends on kce_pkg and kce_alu.
//
// Usage: one ASCII key code per beat on the key channel (key_valid, key_stall,
// key_code). Digits, '+', '-', '*', '/', '=' and 'C' each return one beat on
// the result channel (result_valid, result_stall and the display fields);
// any other key is consumed and returns nothing.
// Digits, clear, repeated operators and zero division go from idle straight to
// the emit state; a pending add, subtract, multiply or divide first waits in
// the calc state until the shared arithmetic unit is done; the unit works
// through multiply and divide one bit per cycle. One key is handled at a time,
// so key_stall stays high from accept until the result is loaded into the
// output register; the next key is taken while that result waits.
// Reset clears the accumulator, the entry, the pending operator (add), the
// phase (digit) and the result register. While result_stall is high the
// result holds; a finished computation waits in the sequencer until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module keypad_calculator_engine #(
	parameter int WORD_WIDTH = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   key_valid,
	output logic                  key_stall,
	input  wire  [7:0]            key_code,
	output logic                  result_valid,
	input  wire                   result_stall,
	output logic [WORD_WIDTH-1:0] display_value,
	output logic [2:0]            display_kind,
	output logic [7:0]            op_char,
	output logic                  clear_screen
);
	import kce_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] entry_q;
	kce_op_t               pend_q;
	kce_phase_t            phase_q;
	logic [WORD_WIDTH-1:0] res_value_q;
	kce_kind_t             res_kind_q;
	kce_char_t             res_char_q;
	logic                  res_clr_q;
	logic                  out_valid_q;

	logic                  take;
	logic                  is_digit;
	logic                  is_op;
	kce_op_t               key_op;
	logic [WORD_WIDTH-1:0] entry_next;
	logic                  out_free;
	logic                  load_out;
	kce_alu_req_t          alu_req;
	kce_alu_stat_t         alu_stat;
	logic [WORD_WIDTH-1:0] alu_result;

	assign key_stall = (state_q != ST_IDLE);
	assign take      = key_valid && !key_stall;
	assign is_digit  = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
	assign out_free  = !out_valid_q || !result_stall;
	assign load_out  = (state_q == ST_EMIT) && out_free;
	assign entry_next = (entry_q << 3) + (entry_q << 1)
		+ WORD_WIDTH'(key_code[3:0]);

	always_comb begin
		is_op  = 1'b1;
		key_op = OP_ADD;
		unique case (key_code)
			KEY_PLUS:  key_op = OP_ADD;
			KEY_MINUS: key_op = OP_SUB;
			KEY_STAR:  key_op = OP_MUL;
			KEY_SLASH: key_op = OP_DIV;
			KEY_EQUAL: key_op = OP_ADD;
			default:   is_op  = 1'b0;
		endcase
	end

	always_comb begin
		alu_req.start = take && is_op && (phase_q == PH_DIGIT)
			&& !((pend_q == OP_DIV) && (entry_q == '0));
		alu_req.op    = pend_q;
	end

	kce_alu #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (acc_q),
		.opb    (entry_q),
		.stat   (alu_stat),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			acc_q         <= '0;
			entry_q       <= '0;
			pend_q        <= OP_ADD;
			phase_q       <= PH_DIGIT;
			res_value_q   <= '0;
			res_kind_q    <= KIND_ENTRY;
			res_char_q    <= CHAR_NONE;
			res_clr_q     <= 1'b0;
			display_value <= '0;
			display_kind  <= KIND_ENTRY;
			op_char       <= CHAR_NONE;
			clear_screen  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && is_digit) begin
						if (phase_q == PH_EQUAL) begin
							acc_q <= '0;
						end
						entry_q     <= entry_next;
						phase_q     <= PH_DIGIT;
						res_value_q <= entry_next;
						res_kind_q  <= KIND_ENTRY;
						res_char_q  <= CHAR_NONE;
						res_clr_q   <= (phase_q != PH_DIGIT);
						state_q     <= ST_EMIT;
					end else if (take && is_op) begin
						pend_q  <= key_op;
						phase_q <= (key_code == KEY_EQUAL) ? PH_EQUAL : PH_SIGN;
						res_kind_q <= (key_code == KEY_EQUAL) ? KIND_EQRES : KIND_OPRES;
						res_char_q <= key_code;
						res_clr_q  <= 1'b0;
						res_value_q <= acc_q;
						state_q    <= ST_EMIT;
						if (phase_q == PH_DIGIT) begin
							entry_q <= '0;
							if (alu_req.start) begin
								state_q <= ST_CALC;
							end else begin
								res_value_q <= '0;
								res_kind_q  <= KIND_ZDIV;
								if (key_code != KEY_EQUAL) begin
									res_char_q <= CHAR_NONE;
									res_clr_q  <= 1'b1;
								end
							end
						end
					end else if (take && (key_code == KEY_CLEAR)) begin
						acc_q       <= '0;
						entry_q     <= '0;
						pend_q      <= OP_ADD;
						res_value_q <= '0;
						res_kind_q  <= KIND_CLEAR;
						res_char_q  <= CHAR_NONE;
						res_clr_q   <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_CALC: begin
					if (alu_stat.done) begin
						acc_q       <= alu_result;
						res_value_q <= alu_result;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						display_value <= res_value_q;
						display_kind  <= res_kind_q;
						op_char       <= res_char_q;
						clear_screen  <= res_clr_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

### src/kce_checker.sv
// Port-level checks for the keypad calculator engine, bound to the top level.
// Depends on kce_pkg and keypad_calculator_engine.
`timescale 1ns / 1ps
`default_nettype none

module kce_checker #(
	parameter int WORD_WIDTH = 32
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  key_valid,
	input wire                  key_stall,
	input wire [7:0]            key_code,
	input wire                  result_valid,
	input wire                  result_stall,
	input wire [WORD_WIDTH-1:0] display_value,
	input wire [2:0]            display_kind,
	input wire [7:0]            op_char,
	input wire                  clear_screen
);
	import kce_pkg::*;

	logic key_known;

	assign key_known = ((key_code >= KEY_ZERO) && (key_code <= KEY_NINE))
		|| (key_code == KEY_PLUS) || (key_code == KEY_MINUS) || (key_code == KEY_STAR)
		|| (key_code == KEY_SLASH) || (key_code == KEY_EQUAL) || (key_code == KEY_CLEAR);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(display_value)
			&& $stable(display_kind) && $stable(op_char) && $stable(clear_screen))
		else $error("stalled result beat changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall && key_known |=> key_stall)
		else $error("key taken while previous key still in work");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (display_kind == KIND_CLEAR) |->
			(display_value == '0) && clear_screen && (op_char == CHAR_NONE))
		else $error("clear beat has wrong fields");

	a_zdiv: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (display_kind == KIND_ZDIV) |->
			(display_value == '0) && ((op_char == KEY_EQUAL) != clear_screen))
		else $error("zero division beat has wrong fields");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (display_kind == KIND_ENTRY) |-> (op_char == CHAR_NONE))
		else $error("entry beat carries an operator character");

endmodule

bind keypad_calculator_engine kce_checker #(
	.WORD_WIDTH(WORD_WIDTH)
) u_kce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.key_valid     (key_valid),
	.key_stall     (key_stall),
	.key_code      (key_code),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.display_value (display_value),
	.display_kind  (display_kind),
	.op_char       (op_char),
	.clear_screen  (clear_screen)
);

`default_nettype wire

### verif/kce_display_checker.sv
// Display checker for the keypad calculator engine: watches the key and result channels,
// predicts each display beat and compares it with what the block returns.
// Depends on kce_pkg.
`timescale 1ns / 1ps

module kce_display_checker
	import kce_pkg::*;
#(
	parameter int WORD_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  key_valid,
	input  wire                  key_stall,
	input  wire [7:0]            key_code,
	input  wire                  result_valid,
	input  wire                  result_stall,
	input  wire [WORD_WIDTH-1:0] display_value,
	input  wire [2:0]            display_kind,
	input  wire [7:0]            op_char,
	input  wire                  clear_screen,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [WORD_WIDTH-1:0] value;
		kce_kind_t             kind;
		kce_char_t             ch;
		logic                  clr;
	} screen_t;

	logic [WORD_WIDTH-1:0] acc;
	logic [WORD_WIDTH-1:0] entry;
	kce_op_t               pend_op;
	kce_phase_t            phase;
	screen_t               screens_due[$];
	int                    bad_count = 0;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// Advance the calculator state by one key; return 1 when the key draws a screen.
	function automatic bit press_key(input kce_char_t key, output screen_t shown);
		bit ok;
		ok = 1'b1;
		shown = '0;
		if (key >= KEY_ZERO && key <= KEY_NINE) begin
			shown.clr = (phase != PH_DIGIT);
			if (phase == PH_EQUAL)
				acc = '0;
			entry = WORD_WIDTH'(entry * WORD_WIDTH'(10) + WORD_WIDTH'(key - KEY_ZERO));
			phase = PH_DIGIT;
			shown.value = entry;
			shown.kind  = KIND_ENTRY;
			shown.ch    = CHAR_NONE;
			return 1'b1;
		end
		if (key == KEY_PLUS || key == KEY_MINUS || key == KEY_STAR || key == KEY_SLASH ||
				key == KEY_EQUAL) begin
			if (phase == PH_DIGIT) begin
				case (pend_op)
					OP_ADD: acc = acc + entry;
					OP_SUB: acc = acc - entry;
					OP_MUL: acc = acc * entry;
					default: begin
						if (entry == '0)
							ok = 1'b0;
						else
							acc = acc / entry;
					end
				endcase
				entry = '0;
			end
			if (key == KEY_EQUAL) begin
				pend_op = OP_ADD;
				phase = PH_EQUAL;
				shown.value = ok ? acc : '0;
				shown.kind  = ok ? KIND_EQRES : KIND_ZDIV;
				shown.ch    = KEY_EQUAL;
				shown.clr   = 1'b0;
				return 1'b1;
			end
			case (key)
				KEY_PLUS:  pend_op = OP_ADD;
				KEY_MINUS: pend_op = OP_SUB;
				KEY_STAR:  pend_op = OP_MUL;
				default:   pend_op = OP_DIV;
			endcase
			phase = PH_SIGN;
			shown.value = ok ? acc : '0;
			shown.kind  = ok ? KIND_OPRES : KIND_ZDIV;
			shown.ch    = ok ? key : CHAR_NONE;
			shown.clr   = !ok;
			return 1'b1;
		end
		if (key == KEY_CLEAR) begin
			acc = '0;
			entry = '0;
			pend_op = OP_ADD;
			shown.value = '0;
			shown.kind  = KIND_CLEAR;
			shown.ch    = CHAR_NONE;
			shown.clr   = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_t want;
		screen_t got;
		if (!arst_n) begin
			acc = '0;
			entry = '0;
			pend_op = OP_ADD;
			phase = PH_DIGIT;
			screens_due.delete();
			outstanding <= 0;
		end else begin
			// a result beat always belongs to a key taken at an earlier edge
			if (result_valid && !result_stall) begin
				got = '{display_value, kce_kind_t'(display_kind), op_char, clear_screen};
				if (screens_due.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: unexpected result beat: value %0d kind %0d op %h clr %b",
							$realtime, got.value, got.kind, got.ch, got.clr);
				end else begin
					want = screens_due.pop_front();
					if (got != want) begin
						bad_count++;
						if (bad_count <= 10)
							$display({"%0t: mismatch: expected value %0d kind %0d op %h clr %b,",
								" got value %0d kind %0d op %h clr %b"}, $realtime,
								want.value, want.kind, want.ch, want.clr,
								got.value, got.kind, got.ch, got.clr);
					end
				end
			end
			if (key_valid && !key_stall) begin
				if (press_key(key_code, want))
					screens_due.push_back(want);
			end
			outstanding <= screens_due.size();
			mismatches <= bad_count;
		end
	end

endmodule

### verif/keypad_calculator_engine_test.sv
// Testbench top for the keypad calculator engine: clock, reset, key stimulus, result
// back-pressure, watchdog and verdict. Depends on kce_pkg, keypad_calculator_engine
// and kce_display_checker.
`timescale 1ns / 1ps

module keypad_calculator_engine_test;
	import kce_pkg::*;

	localparam int WORD_WIDTH = 32;
	localparam int KEY_TARGET = 800;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_AT = 250;
	localparam int HOLD_CYCLES = 400;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  key_valid = 1'b0;
	logic                  key_stall;
	kce_char_t             key_code = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [WORD_WIDTH-1:0] display_value;
	logic [2:0]            display_kind;
	logic [7:0]            op_char;
	logic                  clear_screen;
	int                    mismatches;
	int                    outstanding;

	int keys_sent = 0;
	int drawing_keys = 0;
	bit calm = 1'b0;

	keypad_calculator_engine #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_code     (key_code),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.display_value(display_value),
		.display_kind (display_kind),
		.op_char      (op_char),
		.clear_screen (clear_screen)
	);

	kce_display_checker #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_code     (key_code),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.display_value(display_value),
		.display_kind (display_kind),
		.op_char      (op_char),
		.clear_screen (clear_screen),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit draws_screen(input kce_char_t key);
		return (key >= KEY_ZERO && key <= KEY_NINE) || key == KEY_PLUS || key == KEY_MINUS ||
			key == KEY_STAR || key == KEY_SLASH || key == KEY_EQUAL || key == KEY_CLEAR;
	endfunction

	function automatic kce_char_t pick_digit();
		if ($urandom_range(99) < 25)
			return KEY_ZERO;
		return KEY_ZERO + kce_char_t'($urandom_range(9));
	endfunction

	function automatic kce_char_t pick_op();
		case ($urandom_range(3))
			0: return KEY_PLUS;
			1: return KEY_MINUS;
			2: return KEY_STAR;
			default: return KEY_SLASH;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_key(input kce_char_t key);
		while (!calm && $urandom_range(99) < 23) begin
			key_valid <= 1'b0;
			@(negedge clk);
		end
		key_valid <= 1'b1;
		key_code <= key;
		do
			@(posedge clk);
		while (key_stall);
		keys_sent++;
		if (draws_screen(key))
			drawing_keys++;
		calm = (keys_sent >= 450 && keys_sent < 600);
		@(negedge clk);
	endtask

	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && keys_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= !calm && ($urandom_range(99) < 23);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((key_valid && !key_stall) || (result_valid && !result_stall))
				quiet = 0;
			else begin
				quiet = quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		kce_char_t directed[25];
		int len;
		int pick;
		// unknown keys, entry wrap, repeated operator, zero division on an operator and on
		// equals, digit after equals, clear
		directed = '{8'h00, 8'hFF, KEY_ZERO,
			KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE,
			KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE,
			KEY_STAR, KEY_PLUS, KEY_NINE, KEY_MINUS,
			KEY_SLASH, KEY_ZERO, KEY_PLUS,
			KEY_SLASH, KEY_ZERO, KEY_EQUAL,
			KEY_ZERO + 8'd5, KEY_CLEAR};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_key(directed[i]);
		while (drawing_keys < KEY_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 3);
				repeat (len)
					send_key(pick_digit());
				send_key(($urandom_range(3) == 0) ? KEY_EQUAL : pick_op());
			end else if (pick < 72)
				send_key(pick_op());
			else if (pick < 80)
				send_key(KEY_EQUAL);
			else if (pick < 85)
				send_key(KEY_CLEAR);
			else
				send_key(kce_char_t'($urandom_range(255)));
		end
		key_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (WORD_WIDTH + 20)
			@(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
src/kce_pkg.sv
src/kce_alu.sv
src/keypad_calculator_engine.sv
src/kce_checker.sv
verif/kce_display_checker.sv
verif/keypad_calculator_engine_test.sv
